@@ hdl/separable_gaussian_blur_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion helpers for the separable Gaussian blur core
// Macros for the concurrent checks in the sequencer module.
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_GAUSSIAN_BLUR_CORE_DEFINES_SVH
`define SEPARABLE_GAUSSIAN_BLUR_CORE_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define SGB_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define SGB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hdl/sgb_pkg.sv @@
// ----------------------------------------------------------------------------
// sgb_pkg
// Types, register codes and arithmetic helpers of the blur core.
// ----------------------------------------------------------------------------
package sgb_pkg;

  localparam int PIX_W      = 16;
  localparam int ACC_W      = 36;
  localparam int PROD_W     = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int GEOM_W     = 11;
  localparam int HALF_W     = 3;
  localparam int WSEL_W     = 3;
  localparam int TAP_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_NEAR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_FAR  = 3'd4;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW_ISSUE,
    ST_ROW_WAIT,
    ST_WRITE,
    ST_COL_ISSUE,
    ST_COL_WAIT,
    ST_EMIT,
    ST_NEXT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic              shift;
    logic              issue;
    logic              use_mem;
    logic              tap_ok;
    logic              acc_clr;
    logic              wr;
    logic              emit;
    logic              run_last;
    logic              frame_end;
    logic              bypass;
    logic [WSEL_W-1:0] wsel;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } status_t;

  // Round half up from Q16 and saturate to the pixel range.
  function automatic logic [PIX_W-1:0] round_sat(input logic [ACC_W-1:0] acc);
    logic [ACC_W:0]    sum;
    logic [ACC_W-16:0] q;
    sum = {1'b0, acc} + (ACC_W+1)'(32768);
    q   = sum[ACC_W:16];
    if (|q[ACC_W-16:PIX_W]) begin
      return '1;
    end
    return q[PIX_W-1:0];
  endfunction

endpackage

@@ hdl/separable_gaussian_blur_core.sv @@
// ----------------------------------------------------------------------------
// separable_gaussian_blur_core
// Streaming separable Gaussian blur with clamp-to-edge borders.
//
//   channel   direction  handshake              payload
//   input     in         in_valid_i/in_stall_o  req_type_i, pixel_in_i
//   result    out        out_valid_o/out_stall_i blurred_o, run_last_o, frame_end_o
//   config    in         cfg_we_i               cfg_index_i, cfg_data_i
//
// One shared 16x16 multiplier does every tap. A pixel beat with one result
// holds the input through a row pass, line store write, column pass and
// emit; each further result of an end-of-row beat repeats these steps.
// A flush beat runs a column pass and emit, a pixel with no result a row pass
// and line store write, a pixel with no column due no pass, an ignored beat none.
// Reset clears counters and control; the line store is not cleared.
// A stalled result holds its register and the sequencer waits for it.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_HALF   = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic [sgb_pkg::PIX_W-1:0]          pixel_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [sgb_pkg::PIX_W-1:0]          blurred_o,
  output logic                               run_last_o,
  output logic                               frame_end_o,
  input  logic                               cfg_we_i,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sgb_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int RING = 2 * MAX_HALF + 1;
  localparam int SW   = $clog2(RING);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);

  logic [sgb_pkg::GEOM_W-1:0]     width_q, height_q;
  logic [sgb_pkg::HALF_W-1:0]     half_q, half_eff;
  logic [sgb_pkg::CFG_DATA_W-1:0] wnear_q, wfar_q;
  logic                           cfg_restart;
  logic [31:0]                    w_full, h_full;
  logic [CW-1:0]                  w_last;
  logic [RW-1:0]                  ht_last;

  sgb_pkg::cmd_t    cmd;
  sgb_pkg::status_t status;
  logic [SW-1:0]    tap_off, slot;
  logic [CW-1:0]    col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sgb_pkg::GEOM_W'(1024);
      height_q <= sgb_pkg::GEOM_W'(1024);
      half_q   <= sgb_pkg::HALF_W'(1);
      wnear_q  <= '0;
      wfar_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sgb_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data_i[sgb_pkg::GEOM_W-1:0];
        sgb_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data_i[sgb_pkg::GEOM_W-1:0];
        sgb_pkg::CFG_HALF_WIDTH:   half_q   <= cfg_data_i[sgb_pkg::HALF_W-1:0];
        sgb_pkg::CFG_WEIGHTS_NEAR: wnear_q  <= cfg_data_i;
        sgb_pkg::CFG_WEIGHTS_FAR:  wfar_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_restart = cfg_we_i && ((cfg_index_i == sgb_pkg::CFG_FRAME_WIDTH) ||
                                    (cfg_index_i == sgb_pkg::CFG_FRAME_HEIGHT) ||
                                    (cfg_index_i == sgb_pkg::CFG_HALF_WIDTH));

  // Out-of-range geometry is pulled into the supported frame.
  always_comb begin
    if (width_q == '0) begin
      w_full = 32'd1;
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_full = 32'(MAX_WIDTH);
    end else begin
      w_full = 32'(width_q);
    end
    if (height_q == '0) begin
      h_full = 32'd1;
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_full = 32'(MAX_HEIGHT);
    end else begin
      h_full = 32'(height_q);
    end
    half_eff = (32'(half_q) > 32'(MAX_HALF)) ? sgb_pkg::HALF_W'(MAX_HALF) : half_q;
    w_last   = CW'(w_full - 32'd1);
    ht_last  = RW'(h_full - 32'd1);
  end

  sgb_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_HALF   (MAX_HALF)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .cfg_restart_i (cfg_restart),
    .w_last_i      (w_last),
    .ht_last_i     (ht_last),
    .half_i        (half_eff),
    .status_i      (status),
    .cmd_o         (cmd),
    .tap_off_o     (tap_off),
    .slot_o        (slot),
    .col_o         (col)
  );

  sgb_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HALF  (MAX_HALF)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .tap_off_i      (tap_off),
    .slot_i         (slot),
    .col_i          (col),
    .pixel_i        (pixel_in_i),
    .weights_near_i (wnear_q),
    .weights_far_i  (wfar_q),
    .out_stall_i    (out_stall_i),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .blurred_o      (blurred_o),
    .run_last_o     (run_last_o),
    .frame_end_o    (frame_end_o)
  );

endmodule

@@ hdl/sgb_ctrl.sv @@
// ----------------------------------------------------------------------------
// sgb_ctrl
// Sequencer: frame position counters, tap iteration and address generation.
// ----------------------------------------------------------------------------
`include "separable_gaussian_blur_core_defines.svh"

module sgb_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_HALF   = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic                          cfg_restart_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  w_last_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0] ht_last_i,
  input  logic [sgb_pkg::HALF_W-1:0]    half_i,
  input  sgb_pkg::status_t              status_i,
  output sgb_pkg::cmd_t                 cmd_o,
  output logic [$clog2(2*MAX_HALF+1)-1:0] tap_off_o,
  output logic [$clog2(2*MAX_HALF+1)-1:0] slot_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  col_o
);

  localparam int RING   = 2 * MAX_HALF + 1;
  localparam int SW     = $clog2(RING);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int XW     = CW + 5;
  localparam int YW     = RW + 6;
  localparam int TW     = sgb_pkg::TAP_W;
  localparam int WSEL_W = sgb_pkg::WSEL_W;

  sgb_pkg::state_e st_q, st_d;

  logic [CW-1:0]        in_col_q, out_col_q, x_q, hi_q;
  logic [RW:0]          in_row_q, out_row_q;
  logic [SW-1:0]        in_slot_q, out_slot_q, sl_q, last_slot_q;
  logic signed [TW-1:0] jj_q;
  logic                 emit_q, flush_q;

  logic                 accept, frame_in, out_pend, is_last_col, c_ge_h, any_col, row_ge_h;
  logic signed [TW-1:0] neg_h, pos_h;
  logic signed [XW-1:0] c_s, h_x, jx, sx, idx_s, off_s, wl_s, lo_x;
  logic signed [YW-1:0] rr_s, hl_s;
  logic [SW-1:0]        col_slot, sl_init, hs;
  logic                 tap_last;

  assign accept      = in_valid_i && (st_q == sgb_pkg::ST_IDLE);
  assign frame_in    = in_row_q <= (RW+1)'(ht_last_i);
  assign out_pend    = out_row_q <= (RW+1)'(ht_last_i);
  assign is_last_col = in_col_q == w_last_i;
  assign neg_h       = -$signed({1'b0, half_i});
  assign pos_h       = $signed({1'b0, half_i});
  assign tap_last    = jj_q == pos_h;
  assign row_ge_h    = 32'(in_row_q) >= 32'(half_i);
  assign hs          = SW'(half_i);

  // Column window: first output column of this pixel and whether any is due.
  always_comb begin
    c_s    = $signed(XW'(in_col_q));
    h_x    = $signed(XW'(half_i));
    c_ge_h = c_s >= h_x;
    any_col = is_last_col || c_ge_h;
    lo_x   = c_ge_h ? (c_s - h_x) : '0;
  end

  // Row tap: clamp the column to the frame and locate it in the tap window.
  always_comb begin
    jx    = XW'(jj_q);
    wl_s  = $signed(XW'(w_last_i));
    sx    = $signed(XW'(x_q)) + jx;
    idx_s = sx;
    if (sx < 0) begin
      idx_s = '0;
    end else if (sx > wl_s) begin
      idx_s = wl_s;
    end
    off_s = c_s - idx_s;
  end

  // Column tap: rows above the frame read row 0, rows below repeat the last row.
  always_comb begin
    rr_s = $signed(YW'(out_row_q)) + YW'(jj_q);
    hl_s = $signed(YW'(ht_last_i));
    if (rr_s < 0) begin
      col_slot = '0;
    end else if (rr_s > hl_s) begin
      col_slot = last_slot_q;
    end else begin
      col_slot = sl_q;
    end
    sl_init = (out_slot_q >= hs) ? (out_slot_q - hs) : (out_slot_q + SW'(RING) - hs);
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      sgb_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_type_i == sgb_pkg::REQ_PIXEL) begin
            if (frame_in) begin
              st_d = any_col ? sgb_pkg::ST_ROW_ISSUE : sgb_pkg::ST_FINISH;
            end
          end else if (!frame_in && out_pend) begin
            st_d = sgb_pkg::ST_COL_ISSUE;
          end
        end
      end
      sgb_pkg::ST_ROW_ISSUE: begin
        if (tap_last) st_d = sgb_pkg::ST_ROW_WAIT;
      end
      sgb_pkg::ST_ROW_WAIT: begin
        if (!status_i.busy) st_d = sgb_pkg::ST_WRITE;
      end
      sgb_pkg::ST_WRITE: begin
        st_d = emit_q ? sgb_pkg::ST_COL_ISSUE : sgb_pkg::ST_NEXT;
      end
      sgb_pkg::ST_COL_ISSUE: begin
        if (tap_last) st_d = sgb_pkg::ST_COL_WAIT;
      end
      sgb_pkg::ST_COL_WAIT: begin
        if (!status_i.busy) st_d = sgb_pkg::ST_EMIT;
      end
      sgb_pkg::ST_EMIT: begin
        if (status_i.out_free) st_d = flush_q ? sgb_pkg::ST_FINISH : sgb_pkg::ST_NEXT;
      end
      sgb_pkg::ST_NEXT: begin
        st_d = (x_q == hi_q) ? sgb_pkg::ST_FINISH : sgb_pkg::ST_ROW_ISSUE;
      end
      sgb_pkg::ST_FINISH: begin
        st_d = sgb_pkg::ST_IDLE;
      end
      default: st_d = sgb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.shift     = accept && (req_type_i == sgb_pkg::REQ_PIXEL) && frame_in;
    cmd_o.issue     = (st_q == sgb_pkg::ST_ROW_ISSUE) || (st_q == sgb_pkg::ST_COL_ISSUE);
    cmd_o.use_mem   = st_q == sgb_pkg::ST_COL_ISSUE;
    cmd_o.tap_ok    = (off_s >= 0) && (off_s <= XW'(RING - 1));
    cmd_o.acc_clr   = cmd_o.issue && (jj_q == neg_h);
    cmd_o.wr        = st_q == sgb_pkg::ST_WRITE;
    cmd_o.emit      = (st_q == sgb_pkg::ST_EMIT) && status_i.out_free;
    cmd_o.run_last  = flush_q || (x_q == hi_q);
    cmd_o.frame_end = (out_col_q == w_last_i) && (out_row_q == (RW+1)'(ht_last_i));
    cmd_o.bypass    = half_i == '0;
    cmd_o.wsel      = jj_q[TW-1] ? WSEL_W'(-jj_q) : WSEL_W'(jj_q);
    tap_off_o       = off_s[SW-1:0];
    slot_o          = (st_q == sgb_pkg::ST_WRITE) ? in_slot_q : col_slot;
    col_o           = x_q;
    in_stall_o      = st_q != sgb_pkg::ST_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= sgb_pkg::ST_IDLE;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      in_slot_q   <= '0;
      out_slot_q  <= '0;
      sl_q        <= '0;
      last_slot_q <= '0;
      x_q         <= '0;
      hi_q        <= '0;
      jj_q        <= '0;
      emit_q      <= 1'b0;
      flush_q     <= 1'b0;
    end else begin
      st_q <= st_d;

      if (accept) begin
        flush_q <= req_type_i == sgb_pkg::REQ_FLUSH;
        emit_q  <= row_ge_h;
        if (req_type_i == sgb_pkg::REQ_PIXEL) begin
          x_q  <= lo_x[CW-1:0];
          hi_q <= is_last_col ? w_last_i : lo_x[CW-1:0];
        end else begin
          x_q  <= out_col_q;
          hi_q <= out_col_q;
        end
      end

      if (st_q == sgb_pkg::ST_NEXT && st_d == sgb_pkg::ST_ROW_ISSUE) begin
        x_q <= x_q + CW'(1);
      end

      if ((st_d == sgb_pkg::ST_ROW_ISSUE && st_q != sgb_pkg::ST_ROW_ISSUE) ||
          (st_d == sgb_pkg::ST_COL_ISSUE && st_q != sgb_pkg::ST_COL_ISSUE)) begin
        jj_q <= neg_h;
      end else if (cmd_o.issue) begin
        jj_q <= jj_q + TW'(1);
      end

      // The ring slot follows the unclamped row of each column tap.
      if (st_d == sgb_pkg::ST_COL_ISSUE && st_q != sgb_pkg::ST_COL_ISSUE) begin
        sl_q <= sl_init;
      end else if (st_q == sgb_pkg::ST_COL_ISSUE) begin
        sl_q <= (sl_q == SW'(RING - 1)) ? '0 : sl_q + SW'(1);
        if (rr_s <= hl_s) last_slot_q <= col_slot;
      end

      if (cmd_o.emit) begin
        if (out_col_q == w_last_i) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + (RW+1)'(1);
          out_slot_q <= (out_slot_q == SW'(RING - 1)) ? '0 : out_slot_q + SW'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end

      if (st_q == sgb_pkg::ST_FINISH && !flush_q) begin
        if (is_last_col) begin
          in_col_q  <= '0;
          in_row_q  <= in_row_q + (RW+1)'(1);
          in_slot_q <= (in_slot_q == SW'(RING - 1)) ? '0 : in_slot_q + SW'(1);
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end

      // Frame fully drained, or geometry rewritten: start a new frame.
      if (cfg_restart_i || (st_q == sgb_pkg::ST_FINISH && !out_pend)) begin
        in_col_q   <= '0;
        in_row_q   <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        in_slot_q  <= '0;
        out_slot_q <= '0;
      end
    end
  end

  `SGB_ASSERT_IMPLIES(a_emit_pipe_empty, st_q == sgb_pkg::ST_EMIT, !status_i.busy,
                      "result emitted while the MAC pipeline still runs")
  `SGB_ASSERT_IMPLIES(a_write_pipe_empty, st_q == sgb_pkg::ST_WRITE, !status_i.busy,
                      "row store written before the row sum settled")
  `SGB_ASSERT_HOLDS(a_slot_range,
                    (in_slot_q <= SW'(RING - 1)) && (out_slot_q <= SW'(RING - 1)),
                    "ring slot outside the line store")
  `SGB_ASSERT_IMPLIES(a_idle_rows, st_q == sgb_pkg::ST_IDLE,
                      in_row_q <= (RW+1)'(ht_last_i) + (RW+1)'(1),
                      "input row counter ran past the frame")

endmodule

@@ hdl/sgb_datapath.sv @@
// ----------------------------------------------------------------------------
// sgb_datapath
// Tap window, ring line store, shared multiply-accumulate and result register.
// ----------------------------------------------------------------------------
module sgb_datapath #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HALF  = 7
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sgb_pkg::cmd_t                        cmd_i,
  input  logic [$clog2(2*MAX_HALF+1)-1:0]      tap_off_i,
  input  logic [$clog2(2*MAX_HALF+1)-1:0]      slot_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]         col_i,
  input  logic [sgb_pkg::PIX_W-1:0]            pixel_i,
  input  logic [sgb_pkg::CFG_DATA_W-1:0]       weights_near_i,
  input  logic [sgb_pkg::CFG_DATA_W-1:0]       weights_far_i,
  input  logic                                 out_stall_i,
  output sgb_pkg::status_t                     status_o,
  output logic                                 out_valid_o,
  output logic [sgb_pkg::PIX_W-1:0]            blurred_o,
  output logic                                 run_last_o,
  output logic                                 frame_end_o
);

  localparam int RING = 2 * MAX_HALF + 1;
  localparam int PW   = sgb_pkg::PIX_W;

  logic [PW-1:0] win_q [RING];
  logic [PW-1:0] row_mem_q [RING][MAX_WIDTH];

  logic [PW-1:0]                   rs_q, mem_rd_q, samp2_q, samp3_q, samp, wt;
  logic [sgb_pkg::WSEL_W-1:0]      wsel1_q;
  logic                            src_q, v1_q, v2_q;
  logic [sgb_pkg::PROD_W-1:0]      prod_q;
  logic [sgb_pkg::ACC_W-1:0]       acc_q;
  logic [PW-1:0]                   rounded, hv, pass_val;
  logic                            out_vld_q, run_last_q, frame_end_q;
  logic [PW-1:0]                   out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RING; k++) win_q[k] <= '0;
    end else if (cmd_i.shift) begin
      win_q[0] <= pixel_i;
      for (int k = 1; k < RING; k++) win_q[k] <= win_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      row_mem_q[slot_i][col_i] <= hv;
    end
    if (cmd_i.issue && cmd_i.use_mem) begin
      mem_rd_q <= row_mem_q[slot_i][col_i];
    end
  end

  always_comb begin
    samp = src_q ? mem_rd_q : rs_q;
    if (wsel1_q[2]) begin
      wt = weights_far_i[16*wsel1_q[1:0] +: 16];
    end else begin
      wt = weights_near_i[16*wsel1_q[1:0] +: 16];
    end
  end

  // Three stages: sample fetch, product, accumulate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rs_q    <= cmd_i.tap_ok ? win_q[tap_off_i] : '0;
    src_q   <= cmd_i.use_mem;
    wsel1_q <= cmd_i.wsel;
    prod_q  <= samp * wt;
    samp2_q <= samp;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q   <= acc_q + sgb_pkg::ACC_W'(prod_q);
      samp3_q <= samp2_q;
    end
  end

  // With a zero half width both passes forward the sample unchanged.
  assign rounded  = sgb_pkg::round_sat(acc_q);
  assign hv       = cmd_i.bypass ? win_q[0] : rounded;
  assign pass_val = cmd_i.bypass ? samp3_q : rounded;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q  <= pass_val;
      run_last_q  <= cmd_i.run_last;
      frame_end_q <= cmd_i.frame_end;
    end
  end

  assign status_o.busy     = v1_q || v2_q;
  assign status_o.out_free = !out_vld_q || !out_stall_i;
  assign out_valid_o       = out_vld_q;
  assign blurred_o         = out_data_q;
  assign run_last_o        = run_last_q;
  assign frame_end_o       = frame_end_q;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Separable Gaussian blur core testbench
// Directed table, then random frames of random geometry and weights, with
// random gaps and stalls on both channels; every result beat is checked
// against a typed expectation or a behavioral blur computed in this file.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [sgb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
  localparam int LINE_W = 1024;
  localparam int LINES = 15;
  localparam int SETTLE = 400;

  typedef enum logic [1:0] {OP_CFG, OP_PIX, OP_FLUSH} op_e;

  typedef struct packed {
    logic [sgb_pkg::PIX_W-1:0] blurred;
    logic                      run_last;
    logic                      frame_end;
  } beat_t;

  typedef struct {
    op_e             op;
    logic [2:0]      idx;
    logic [63:0]     data;
    int              nexp;  // -1: computed, 0: no beat, 1: one typed beat
    beat_t           typed;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = sgb_pkg::REQ_PIXEL;
  logic [sgb_pkg::PIX_W-1:0] pixel_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [sgb_pkg::PIX_W-1:0] blurred_o;
  logic run_last_o;
  logic frame_end_o;
  logic cfg_we_i = 1'b0;
  logic [sgb_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [sgb_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  always #4 clk_i = ~clk_i;

  separable_gaussian_blur_core u_dut (.*);

  // Behavioral copy of the blur state.
  logic [15:0] tap_win [LINES];
  logic [15:0] line_buf [LINES*LINE_W];
  int unsigned in_col, in_row, out_col, out_row;
  int unsigned geo_w = 1024, geo_h = 1024, geo_half = 1;
  logic [63:0] w_near = '0, w_far = '0;
  beat_t blur_q[$];
  bit failed = 0;
  int beats_seen = 0;

  function automatic int eff_w();
    return (geo_w == 0) ? 1 : (geo_w > 1024 ? 1024 : geo_w);
  endfunction
  function automatic int eff_h();
    return (geo_h == 0) ? 1 : (geo_h > 1024 ? 1024 : geo_h);
  endfunction

  function automatic longint unsigned weight(int k);
    return (k < 4) ? w_near[16*k +: 16] : w_far[16*(k-4) +: 16];
  endfunction

  function automatic logic [15:0] rnd_sat(longint unsigned acc);
    longint unsigned q;
    q = (acc + 32768) >> 16;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic void restart_counts();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endfunction

  function automatic logic [15:0] row_blur(int x, int c, int w, int h);
    longint unsigned acc;
    int idx, off;
    longint unsigned s;
    acc = 0;
    for (int j = -h; j <= h; j++) begin
      idx = x + j;
      if (idx < 0) idx = 0;
      if (idx > w - 1) idx = w - 1;
      off = c - idx;
      s = (off >= 0 && off < LINES) ? tap_win[off] : 0;
      acc += s * weight(j < 0 ? -j : j);
    end
    return rnd_sat(acc);
  endfunction

  function automatic logic [15:0] col_blur(int x, int oy, int ht, int h);
    longint unsigned acc;
    int row;
    longint unsigned s;
    acc = 0;
    for (int j = -h; j <= h; j++) begin
      row = oy + j;
      if (row < 0) row = 0;
      if (row > ht - 1) row = ht - 1;
      s = line_buf[(row % LINES) * LINE_W + (x % LINE_W)];
      acc += s * weight(j < 0 ? -j : j);
    end
    return rnd_sat(acc);
  endfunction

  function automatic void push_out(logic [15:0] v, int w, int ht);
    beat_t b;
    b.blurred = v;
    b.run_last = 1'b0;
    b.frame_end = (out_col == w - 1 && out_row == ht - 1);
    blur_q.push_back(b);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
  endfunction

  function automatic void blur_step(logic req, logic [15:0] pix);
    int w, ht, h, c, r, lo, hi, first;
    bit any;
    logic [15:0] hv;
    beat_t b;
    w = eff_w(); ht = eff_h(); h = geo_half;
    first = blur_q.size();
    if (req == sgb_pkg::REQ_PIXEL) begin
      if (in_row >= ht) return;
      c = in_col; r = in_row;
      for (int i = LINES - 1; i > 0; i--) tap_win[i] = tap_win[i-1];
      tap_win[0] = pix;
      any = 1; lo = 0; hi = 0;
      if (c == w - 1) begin
        lo = (c >= h) ? c - h : 0;
        hi = w - 1;
      end else if (c >= h) begin
        lo = c - h;
        hi = lo;
      end else begin
        any = 0;
      end
      if (any) begin
        for (int x = lo; x <= hi; x++) begin
          hv = (h == 0) ? pix : row_blur(x, c, w, h);
          line_buf[(r % LINES) * LINE_W + (x % LINE_W)] = hv;
          if (r >= h) push_out((h == 0) ? hv : col_blur(x, r - h, ht, h), w, ht);
        end
      end
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end else begin
      if (in_row < ht) return;
      if (out_row >= ht) begin
        restart_counts();
        return;
      end
      if (h == 0) push_out(line_buf[(out_row % LINES) * LINE_W + (out_col % LINE_W)], w, ht);
      else push_out(col_blur(out_col, out_row, ht, h), w, ht);
    end
    if (blur_q.size() > first) begin
      b = blur_q.pop_back();
      b.run_last = 1'b1;
      blur_q.push_back(b);
    end
    if (out_row >= ht) restart_counts();
  endfunction

  // Wait for every expected beat, then let the core finish any beat that
  // produces no result before touching the registers.
  task automatic wait_idle();
    while (blur_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    in_valid_i <= 1'b0;
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      sgb_pkg::CFG_FRAME_WIDTH: begin
        geo_w = data[10:0]; restart_counts();
      end
      sgb_pkg::CFG_FRAME_HEIGHT: begin
        geo_h = data[10:0]; restart_counts();
      end
      sgb_pkg::CFG_HALF_WIDTH: begin
        geo_half = data[2:0]; restart_counts();
      end
      sgb_pkg::CFG_WEIGHTS_NEAR: w_near = data;
      sgb_pkg::CFG_WEIGHTS_FAR: w_far = data;
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drives one input beat; nexp < 0 keeps the computed expectation.
  task automatic send_beat(logic req, logic [15:0] pix, int nexp, beat_t typed);
    int gap;
    int first;
    logic stalled;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    first = blur_q.size();
    blur_step(req, pix);
    if (nexp >= 0) begin
      // Only the beats of this step are replaced by the typed expectation.
      while (blur_q.size() > first) void'(blur_q.pop_back());
      if (nexp > 0) blur_q.push_back(typed);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    pixel_in_i <= pix;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  function automatic beat_t mk(logic [15:0] v, logic l, logic e);
    beat_t b;
    b.blurred = v; b.run_last = l; b.frame_end = e;
    return b;
  endfunction

  // Result side: random stalls, plus one long hold-off that backs up the core.
  initial begin
    int hold;
    bit pressed;
    hold = 0;
    pressed = 0;
    forever begin
      @(posedge clk_i);
      if (!pressed && beats_seen >= 60 && in_valid_i) begin
        pressed = 1;
        out_stall_i <= 1'b1;
        repeat (800) @(posedge clk_i);
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        hold = pick_gap();
        out_stall_i <= (hold > 0);
      end
    end
  end

  always @(negedge clk_i) begin
    beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_seen++;
      if (blur_q.size() == 0) begin
        failed = 1;
        $display("%0t: unexpected beat blurred=%h run_last=%b frame_end=%b",
                 $time, blurred_o, run_last_o, frame_end_o);
      end else begin
        want = blur_q.pop_front();
        if (blurred_o !== want.blurred) begin
          failed = 1;
          $display("%0t: blurred expected %h actual %h", $time, want.blurred, blurred_o);
        end
        if (run_last_o !== want.run_last) begin
          failed = 1;
          $display("%0t: run_last expected %b actual %b", $time, want.run_last, run_last_o);
        end
        if (frame_end_o !== want.frame_end) begin
          failed = 1;
          $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                   frame_end_o);
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    row_t plan[$];
    int items, phase, w, h, npix;
    logic [63:0] wn, wf;
    beat_t none;
    none = '0;
    for (int i = 0; i < LINES; i++) tap_win[i] = '0;
    restart_counts();
    // 1x1 pass-through, a flush with nothing to drain, an ignored register, then a 3x2
    // frame with an early flush and a pixel sent while the frame drains.
    plan = '{
      '{OP_CFG, sgb_pkg::CFG_FRAME_WIDTH, 64'd1, -1, none},
      '{OP_CFG, sgb_pkg::CFG_FRAME_HEIGHT, 64'd1, -1, none},
      '{OP_CFG, sgb_pkg::CFG_HALF_WIDTH, 64'd0, -1, none},
      '{OP_PIX, 3'd0, 64'h0000, 1, mk(16'h0000, 1'b1, 1'b1)},
      '{OP_PIX, 3'd0, 64'hFFFF, 1, mk(16'hFFFF, 1'b1, 1'b1)},
      '{OP_FLUSH, 3'd0, 64'h0, 0, none},
      '{OP_CFG, CFG_UNUSED, 64'd3, -1, none},
      '{OP_CFG, sgb_pkg::CFG_HALF_WIDTH, 64'd1, -1, none},
      '{OP_CFG, sgb_pkg::CFG_WEIGHTS_NEAR, 64'h0000_0000_4000_8000, -1, none},
      '{OP_CFG, sgb_pkg::CFG_WEIGHTS_FAR, 64'hFFFF_FFFF_FFFF_FFFF, -1, none},
      '{OP_CFG, sgb_pkg::CFG_FRAME_WIDTH, 64'd3, -1, none},
      '{OP_CFG, sgb_pkg::CFG_FRAME_HEIGHT, 64'd2, -1, none},
      '{OP_PIX, 3'd0, 64'hFFFF, -1, none},
      '{OP_PIX, 3'd0, 64'h0000, -1, none},
      '{OP_PIX, 3'd0, 64'h1234, -1, none},
      '{OP_FLUSH, 3'd0, 64'h0, 0, none},
      '{OP_PIX, 3'd0, 64'h8000, -1, none},
      '{OP_PIX, 3'd0, 64'hFFFF, -1, none},
      '{OP_PIX, 3'd0, 64'h0001, -1, none},
      '{OP_PIX, 3'd0, 64'hAAAA, 0, none},
      '{OP_FLUSH, 3'd0, 64'h0, -1, none},
      '{OP_FLUSH, 3'd0, 64'h0, -1, none},
      '{OP_FLUSH, 3'd0, 64'h0, -1, none},
      '{OP_FLUSH, 3'd0, 64'h0, -1, none}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[i]) begin
      if (plan[i].op == OP_CFG) write_reg(plan[i].idx, plan[i].data);
      else send_beat(plan[i].op == OP_FLUSH, plan[i].data[15:0], plan[i].nexp,
                     plan[i].typed);
    end

    items = 0;
    phase = 0;
    while (items < 380) begin
      case ($urandom_range(0, 19))
        0: w = 0;
        1: w = 2047;
        default: w = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 19))
        0: h = 0;
        1: h = 2047;
        default: h = $urandom_range(1, 10);
      endcase
      if (w >= 1024 && h >= 1024) h = 1;
      if (phase == 3) begin
        w = 1024; h = 1;
      end else if (phase == 6) begin
        w = 1; h = 1024;
      end
      if ($urandom_range(0, 2) == 0) begin
        wn = {$urandom, $urandom};
        wf = {$urandom, $urandom};
      end else begin
        // Roughly normalized kernel with a falling profile.
        wn = {16'($urandom_range(0, 2000)), 16'($urandom_range(2000, 8000)),
              16'($urandom_range(6000, 14000)), 16'($urandom_range(14000, 40000))};
        wf = {16'($urandom_range(0, 300)), 16'($urandom_range(0, 600)),
              16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1500))};
      end
      write_reg(sgb_pkg::CFG_WEIGHTS_NEAR, wn);
      write_reg(sgb_pkg::CFG_WEIGHTS_FAR, wf);
      write_reg(sgb_pkg::CFG_FRAME_WIDTH, w);
      write_reg(sgb_pkg::CFG_FRAME_HEIGHT, h);
      write_reg(sgb_pkg::CFG_HALF_WIDTH, (phase % 4 == 1) ? 7 : $urandom_range(0, 7));
      npix = eff_w() * eff_h();
      // Now and then the frame is abandoned part way.
      if ($urandom_range(0, 9) == 0) npix = $urandom_range(1, npix);
      // Oversized frames are always cut short to keep the run brief.
      if (npix > 48) npix = $urandom_range(1, 48);
      for (int p = 0; p < npix; p++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_beat(sgb_pkg::REQ_FLUSH, 16'($urandom), -1, none);
          items++;
        end
        send_beat(sgb_pkg::REQ_PIXEL, 16'($urandom), -1, none);
        items++;
      end
      while (in_row >= eff_h()) begin
        if ($urandom_range(0, 9) == 0) begin
          send_beat(sgb_pkg::REQ_PIXEL, 16'($urandom), -1, none);
          items++;
        end
        send_beat(sgb_pkg::REQ_FLUSH, 16'($urandom), -1, none);
        items++;
      end
      phase++;
    end
    in_valid_i <= 1'b0;
    while (blur_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
